>>> src/ilst_pkg.sv
package ilst_pkg;

  localparam int unsigned DefCapacity  = 64;
  localparam int unsigned DefDataWidth = 32;

  localparam int unsigned KindW   = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  typedef enum logic [KindW-1:0] {
    K_GET          = 3'd0,
    K_INSERT_AT    = 3'd1,
    K_INSERT_FRONT = 3'd2,
    K_INSERT_BACK  = 3'd3,
    K_DELETE_AT    = 3'd4,
    K_DELETE_FRONT = 3'd5,
    K_DELETE_BACK  = 3'd6,
    K_CLEAR        = 3'd7
  } ilst_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ilst_status_e;

endpackage

>>> src/ilst_req_if.sv
interface ilst_req_if;
  import ilst_pkg::*;
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [PosW-1:0]    position;
  logic [WordW-1:0]   data_word;

  modport source (output valid, kind, position, data_word, input ready);
  modport sink   (input valid, kind, position, data_word, output ready);
endinterface

>>> src/ilst_rsp_if.sv
interface ilst_rsp_if;
  import ilst_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [WordW-1:0]   read_word;
  logic [CountW-1:0]  element_count;
  logic               is_empty;

  modport source (output valid, status, read_word, element_count, is_empty, input ready);
  modport sink   (input valid, status, read_word, element_count, is_empty, output ready);
endinterface

>>> src/ilst_mem.sv
module ilst_mem #(
  parameter int unsigned Depth = ilst_pkg::DefCapacity,
  parameter int unsigned Width = ilst_pkg::DefDataWidth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/ilst_ctrl.sv
module ilst_ctrl #(
  parameter int unsigned Capacity  = ilst_pkg::DefCapacity,
  parameter int unsigned DataWidth = ilst_pkg::DefDataWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ilst_req_if.sink                    req_i,
  ilst_rsp_if.source                  rsp_o,
  output logic                        mem_we_o,
  output logic [$clog2(Capacity)-1:0] mem_waddr_o,
  output logic [DataWidth-1:0]        mem_wdata_o,
  output logic [$clog2(Capacity)-1:0] mem_raddr_o,
  input  logic [DataWidth-1:0]        mem_rdata_i
);
  import ilst_pkg::*;

  localparam int unsigned AW   = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CW   = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {S_IDLE, S_GET, S_UP, S_PUT, S_DN} state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [AW-1:0]      tgt_q, tgt_d;
  logic [DataWidth-1:0] word_q, word_d;
  logic               ov_q, ov_d;
  ilst_status_e       st_q, st_d;
  logic [WordW-1:0]   rw_q, rw_d;

  logic [CW-1:0] posw, cntw, capw, pw;
  logic          accept, range_err;
  ilst_kind_e    kind;

  assign posw   = CW'(req_i.position);
  assign cntw   = CW'(cnt_q);
  assign capw   = CW'(Capacity);
  assign kind   = ilst_kind_e'(req_i.kind);
  assign req_i.ready = (state_q == S_IDLE) && (!ov_q || rsp_o.ready);
  assign accept = req_i.valid && req_i.ready;

  assign rsp_o.valid         = ov_q;
  assign rsp_o.status        = st_q;
  assign rsp_o.read_word     = rw_q;
  assign rsp_o.element_count = CountW'(cnt_q);
  assign rsp_o.is_empty      = (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    tgt_d   = tgt_q;
    word_d  = word_q;
    ov_d    = ov_q && !rsp_o.ready;
    st_d    = st_q;
    rw_d    = rw_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q + AW'(1);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ptr_q;
    pw          = '0;
    range_err   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          word_d = DataWidth'(req_i.data_word);
          rw_d   = '0;
          st_d   = ST_OK;
          unique case (kind)
            K_GET: begin
              if (posw < cntw) begin
                mem_raddr_o = AW'(posw);
                state_d     = S_GET;
              end else begin
                ov_d = 1'b1;
                st_d = ST_RANGE;
              end
            end
            K_INSERT_AT, K_INSERT_FRONT, K_INSERT_BACK: begin
              priority case (kind)
                K_INSERT_AT:    pw = posw;
                K_INSERT_FRONT: pw = '0;
                default:        pw = cntw;
              endcase
              range_err = (kind == K_INSERT_AT) && (posw != '0) && (posw >= cntw);
              if (range_err) begin
                ov_d = 1'b1;
                st_d = ST_RANGE;
              end else if (cntw == capw) begin
                ov_d = 1'b1;
                st_d = ST_FULL;
              end else if (pw < cntw) begin
                // open a gap by moving the tail up one place, last element first
                mem_raddr_o = AW'(cntw - CW'(1));
                ptr_d       = AW'(cntw - CW'(1));
                tgt_d       = AW'(pw);
                state_d     = S_UP;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(pw);
                mem_wdata_o = DataWidth'(req_i.data_word);
                cnt_d       = cnt_q + CntW'(1);
                ov_d        = 1'b1;
              end
            end
            K_DELETE_AT, K_DELETE_FRONT, K_DELETE_BACK: begin
              priority case (kind)
                K_DELETE_AT:    pw = posw;
                K_DELETE_FRONT: pw = '0;
                default:        pw = cntw - CW'(1);
              endcase
              if ((cntw == '0) || (pw >= cntw)) begin
                ov_d = 1'b1;
                st_d = ST_RANGE;
              end else if (pw + CW'(1) < cntw) begin
                mem_raddr_o = AW'(pw + CW'(1));
                ptr_d       = AW'(pw + CW'(1));
                state_d     = S_DN;
              end else begin
                cnt_d = cnt_q - CntW'(1);
                ov_d  = 1'b1;
              end
            end
            default: begin
              cnt_d = '0;
              ov_d  = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        rw_d    = WordW'(mem_rdata_i);
        ov_d    = 1'b1;
        state_d = S_IDLE;
      end
      S_UP: begin
        mem_we_o = 1'b1;
        if (ptr_q == tgt_q) begin
          state_d = S_PUT;
        end else begin
          mem_raddr_o = ptr_q - AW'(1);
          ptr_d       = ptr_q - AW'(1);
        end
      end
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q;
        mem_wdata_o = word_q;
        cnt_d       = cnt_q + CntW'(1);
        ov_d        = 1'b1;
        state_d     = S_IDLE;
      end
      S_DN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q - AW'(1);
        if (CntW'(ptr_q) == cnt_q - CntW'(1)) begin
          cnt_d   = cnt_q - CntW'(1);
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end else begin
          mem_raddr_o = ptr_q + AW'(1);
          ptr_d       = ptr_q + AW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      ptr_q   <= '0;
      tgt_q   <= '0;
      word_q  <= '0;
      st_q    <= ST_OK;
      rw_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      ptr_q   <= ptr_d;
      tgt_q   <= tgt_d;
      word_q  <= word_d;
      st_q    <= st_d;
      rw_q    <= rw_d;
    end
  end
endmodule

>>> src/indexed_list_store_unit.sv
// channel | dir | fields                                          | transfer
// req_i   | in  | kind, position, data_word                       | valid & ready
// rsp_o   | out | status, read_word, element_count, is_empty      | valid & ready
//
// one request at a time; the result register frees the input once it drains
// get reads the element memory before it answers; clear, failed requests and tail
// insert/delete need no memory read; insert/delete in the middle move the elements
// one by one, set by the single read and single write port of the element memory
// reset clears the count and the result register; the memory is not cleared
// a stalled result holds the next request off until it is taken
module indexed_list_store_unit #(
  parameter int unsigned CAPACITY   = ilst_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = ilst_pkg::DefDataWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilst_req_if.sink   req_i,
  ilst_rsp_if.source rsp_o
);
  import ilst_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  // element memory port signals
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // sequencer: decodes the request, walks the shift and forms the result
  ilst_ctrl #(
    .Capacity  (CAPACITY),
    .DataWidth (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // elements in position order, one synchronous read port
  ilst_mem #(
    .Depth (CAPACITY),
    .Width (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );
endmodule

>>> src/ilst_checker.sv
module ilst_checker #(
  parameter int unsigned CAPACITY = ilst_pkg::DefCapacity
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ilst_pkg::StatusW-1:0] status,
  input logic [ilst_pkg::WordW-1:0]   read_word,
  input logic [ilst_pkg::CountW-1:0]  element_count,
  input logic                       is_empty
);
  import ilst_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (is_empty == (element_count == '0)))
    else $error("empty flag disagrees with count");

  a_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != ST_OK) |-> (read_word == '0))
    else $error("read word on failed request");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (element_count <= CountW'(CAPACITY)) &&
                  ((status != ST_FULL) || (element_count == CountW'(CAPACITY))))
    else $error("count out of bounds");
endmodule

bind indexed_list_store_unit ilst_checker #(.CAPACITY(CAPACITY)) u_ilst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (rsp_o.valid),
  .out_ready     (rsp_o.ready),
  .status        (rsp_o.status),
  .read_word     (rsp_o.read_word),
  .element_count (rsp_o.element_count),
  .is_empty      (rsp_o.is_empty)
);
